FILE: hw/rtl/base26_range_splitter_core_defines.svh
// Assertion macros shared by the range splitter RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BASE26_RANGE_SPLITTER_CORE_DEFINES_SVH
`define BASE26_RANGE_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication.
`define B26RS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define B26RS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/b26rs_pkg.sv
`default_nettype none

package b26rs_pkg;

    // Letter packing.
    localparam int LETTER_BITS   = 5;
    localparam int FIELD_LETTERS = 8;
    localparam int WORD_BITS     = LETTER_BITS * FIELD_LETTERS;
    localparam int RADIX         = 26;
    localparam int MAX_DIGIT     = RADIX - 1;

    // Chunk size register.
    localparam int CHUNK_BITS = 32;

    typedef logic [LETTER_BITS-1:0] digit_t;
    typedef digit_t [FIELD_LETTERS-1:0] digit_vec_t;

    // Reset chunk size is 500000, so the addend is 499999 = 1,2,11,16,19 in base 26.
    localparam digit_vec_t ADD_RESET_DIGITS = {
        5'd0, 5'd0, 5'd0, 5'd1, 5'd2, 5'd11, 5'd16, 5'd19
    };

    // Work bundle handed from cell to cell along the chain.
    typedef struct packed {
        logic [3:0]           len;
        logic [WORD_BITS-1:0] lo_raw;
        logic [WORD_BITS-1:0] hi_raw;
        logic                 carry;
        logic                 inc_carry;
        logic                 lt;
        logic                 ovf;
        logic [WORD_BITS-1:0] lo_w;
        logic [WORD_BITS-1:0] sum_w;
        logic [WORD_BITS-1:0] rest_w;
        logic [WORD_BITS-1:0] hi_w;
    } work_t;

    // Letters above the last valid one read as the last valid one.
    function automatic digit_t clamp_digit(input digit_t d);
        digit_t r;
        r = (d > digit_t'(MAX_DIGIT)) ? digit_t'(MAX_DIGIT) : d;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/b26rs_cell.sv
`default_nettype none

module b26rs_cell
    import b26rs_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  work_t  up_work,
    input  digit_t add_digit,
    output logic   dn_valid,
    input  logic   dn_ready,
    output work_t  dn_work
);

    logic       valid_reg;
    work_t      work_reg;
    work_t      work_next;
    logic       active;
    digit_t     lo_d;
    digit_t     hi_d;
    digit_t     sum_d;
    digit_t     rest_d;
    logic [5:0] sum_t;
    logic [5:0] inc_t;
    logic       sum_cy;
    logic       inc_cy;

    // One base-26 digit of start + addend, of that sum + 1, and of the compare.
    always_comb
    begin
        active = (up_work.len > 4'(IDX));
        lo_d   = clamp_digit(up_work.lo_raw[LETTER_BITS*IDX +: LETTER_BITS]);
        hi_d   = clamp_digit(up_work.hi_raw[LETTER_BITS*IDX +: LETTER_BITS]);
        sum_t  = 6'(lo_d) + 6'(add_digit) + 6'(up_work.carry);
        sum_cy = (sum_t >= 6'(RADIX));
        sum_d  = sum_cy ? 5'(sum_t - 6'(RADIX)) : 5'(sum_t);
        inc_t  = 6'(sum_d) + 6'(up_work.inc_carry);
        inc_cy = (inc_t == 6'(RADIX));
        rest_d = inc_cy ? '0 : 5'(inc_t);

        work_next = up_work;
        if (active)
        begin
            work_next.carry     = sum_cy;
            work_next.inc_carry = inc_cy;
            // The compare runs from the least significant digit up.
            work_next.lt        = (sum_d < hi_d) || ((sum_d == hi_d) && up_work.lt);
            work_next.lo_w[LETTER_BITS*IDX +: LETTER_BITS]   = lo_d;
            work_next.hi_w[LETTER_BITS*IDX +: LETTER_BITS]   = hi_d;
            work_next.sum_w[LETTER_BITS*IDX +: LETTER_BITS]  = sum_d;
            work_next.rest_w[LETTER_BITS*IDX +: LETTER_BITS] = rest_d;
        end
        else
        begin
            // Past the word length, any addend digit means the sum does not fit.
            work_next.ovf = up_work.ovf || (add_digit != '0);
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    // Stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            work_reg <= work_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/b26rs_cvt.sv
`default_nettype none

module b26rs_cvt
    import b26rs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CHUNK_BITS-1:0] cfg_data,
    output logic                  busy,
    output digit_vec_t            add_digits
);

    logic                  busy_reg;
    logic                  busy_next;
    logic [4:0]            cnt_reg;
    logic [4:0]            cnt_next;
    logic [CHUNK_BITS-1:0] shift_reg;
    logic [CHUNK_BITS-1:0] shift_next;
    digit_vec_t            digits_reg;
    digit_vec_t            digits_next;
    digit_vec_t            doubled;
    logic                  wr;

    assign wr = cfg_valid && cfg_ready;

    // Doubles the base-26 value and adds the next binary bit, MSB first.
    always_comb
    begin
        logic       cy;
        logic [5:0] t;
        cy = shift_reg[CHUNK_BITS-1];
        for (int k = 0; k < FIELD_LETTERS; k++)
        begin
            t = {digits_reg[k], 1'b0} + 6'(cy);
            if (t >= 6'(RADIX))
            begin
                doubled[k] = 5'(t - 6'(RADIX));
                cy         = 1'b1;
            end
            else
            begin
                doubled[k] = 5'(t);
                cy         = 1'b0;
            end
        end
    end

    // Load on a write, then one bit per cycle for the full register width.
    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        digits_next = digits_reg;
        if (wr)
        begin
            busy_next   = 1'b1;
            cnt_next    = 5'(CHUNK_BITS - 1);
            shift_next  = (cfg_data == '0) ? '0 : cfg_data - CHUNK_BITS'(1);
            digits_next = '0;
        end
        else if (busy_reg)
        begin
            digits_next = doubled;
            shift_next  = {shift_reg[CHUNK_BITS-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    // Control and converted addend.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            digits_reg <= ADD_RESET_DIGITS;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            digits_reg <= digits_next;
        end
    end

    // Binary shift register.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign cfg_ready  = !busy_reg;
    assign busy       = busy_reg;
    assign add_digits = digits_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/base26_range_splitter_core.sv
// Path: a request is registered in each digit cell in turn, then in the result register.
// Throughput: one request per cycle unless stalled; each cell holds one request in flight.
// A chunk_size write runs a binary to base-26 conversion of the addend in the
// converter, and requests are stalled until it finishes.
// Reset: all stage valid flags and the result valid flag clear; chunk_size reads 500000.
`default_nettype none

`include "base26_range_splitter_core_defines.svh"

module base26_range_splitter_core
    import b26rs_pkg::*;
#(
    parameter int WORD_LEN = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CHUNK_BITS-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [WORD_BITS-1:0]  range_low,
    input  logic [WORD_BITS-1:0]  range_high,
    input  logic [3:0]            word_length,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  split,
    output logic [WORD_BITS-1:0]  chunk_low,
    output logic [WORD_BITS-1:0]  chunk_high,
    output logic [WORD_BITS-1:0]  rest_low
);

    localparam int NCELL = (WORD_LEN < FIELD_LETTERS) ? WORD_LEN : FIELD_LETTERS;

    logic                 cvt_busy;
    digit_vec_t           add_digits;
    logic                 add_beyond;
    logic [NCELL:0]       chain_valid;
    logic [NCELL:0]       chain_ready;
    work_t                chain_work [NCELL+1];
    work_t                tail;
    logic                 out_load;
    logic                 split_next;
    logic                 res_valid_reg;
    logic                 split_reg;
    logic [WORD_BITS-1:0] chunk_low_reg;
    logic [WORD_BITS-1:0] chunk_high_reg;
    logic [WORD_BITS-1:0] rest_low_reg;

    // Chunk size register, held as base-26 digits of chunk_size - 1.
    b26rs_cvt u_cvt
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .busy       (cvt_busy),
        .add_digits (add_digits)
    );

    // Nonzero addend digits beyond the last cell always overflow the word.
    always_comb
    begin
        add_beyond = 1'b0;
        for (int k = 0; k < FIELD_LETTERS; k++)
        begin
            if (k >= NCELL)
            begin
                add_beyond = add_beyond || (add_digits[k] != '0);
            end
        end
    end

    // Request entry: cap the length and seed the carry chains.
    always_comb
    begin
        chain_work[0]           = '0;
        chain_work[0].len       = (word_length > 4'(NCELL)) ? 4'(NCELL) : word_length;
        chain_work[0].lo_raw    = range_low;
        chain_work[0].hi_raw    = range_high;
        chain_work[0].inc_carry = 1'b1;
    end

    assign chain_valid[0] = req_valid && !cvt_busy;
    assign req_stall      = !chain_ready[0] || cvt_busy;

    // One cell per letter, least significant letter first.
    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        b26rs_cell #(
            .IDX (g)
        ) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (chain_valid[g]),
            .up_ready  (chain_ready[g]),
            .up_work   (chain_work[g]),
            .add_digit (add_digits[g]),
            .dn_valid  (chain_valid[g+1]),
            .dn_ready  (chain_ready[g+1]),
            .dn_work   (chain_work[g+1])
        );
    end

    // Final decision on the fully processed request.
    assign tail       = chain_work[NCELL];
    assign split_next = !tail.carry && !tail.ovf && !add_beyond && tail.lt;
    assign out_load   = !res_valid_reg || !res_stall;
    assign chain_ready[NCELL] = out_load;

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= chain_valid[NCELL];
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_load && chain_valid[NCELL])
        begin
            split_reg      <= split_next;
            chunk_low_reg  <= tail.lo_w;
            chunk_high_reg <= split_next ? tail.sum_w : tail.hi_w;
            rest_low_reg   <= split_next ? tail.rest_w : tail.lo_w;
        end
    end

    assign res_valid  = res_valid_reg;
    assign split      = split_reg;
    assign chunk_low  = chunk_low_reg;
    assign chunk_high = chunk_high_reg;
    assign rest_low   = rest_low_reg;

    `B26RS_ASSERT_NOW(a_busy_stalls, cvt_busy, req_stall, "request taken during conversion")
    `B26RS_ASSERT_NEXT(a_write_busy, cfg_valid && cfg_ready, cvt_busy, "write did not start conversion")
    `B26RS_ASSERT_NOW(a_chunk_order, res_valid && split, chunk_low <= chunk_high, "chunk runs backward")
    `B26RS_ASSERT_NOW(a_rest_after, res_valid && split, rest_low > chunk_high, "rest overlaps chunk")

endmodule

`default_nettype wire
